// File: design/pvm_pkg.sv
// Shared types, codes and constants for the polyphonic ADSR voice mixer.
package pvm_pkg;

  localparam int IN_W   = 128;
  localparam int OUT_W  = 40;
  localparam int LEN_W  = 20;
  localparam int SL_W   = 16;
  localparam int FREQ_W = 12;
  localparam int LVL_W  = 9;
  localparam int PH_W   = 17;
  localparam int OFF_W  = 22;
  localparam int NUM_W  = 38;
  localparam int QUO_W  = 17;
  localparam int DEN_W  = 20;
  localparam int REM_W  = NUM_W - QUO_W;
  localparam int DCNT_W = $clog2(QUO_W + 1);
  localparam int MAG_W  = 49;
  localparam int SPLIT  = 24;

  localparam logic OP_NOTE_ON = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic [15:0]      LFSR_SEED = 16'hACE1;
  localparam logic [15:0]      LFSR_TAPS = 16'hB400;
  localparam logic [13:0]      OUT_SCALE = 14'd10922;
  localparam logic [QUO_W-1:0] ENV_FULL  = 17'd65536;
  localparam logic [LVL_W-1:0] LVL_FULL  = 9'd256;

  typedef enum logic [1:0] {
    WAVE_SINE,
    WAVE_SQUARE,
    WAVE_SAW,
    WAVE_NOISE
  } wave_t;

  typedef enum logic [1:0] {
    ENV_DIRECT,
    ENV_RISE,
    ENV_FALL,
    ENV_RELEASE
  } env_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOAD,
    ST_WAVE,
    ST_WDIV,
    ST_ENV,
    ST_EDIV,
    ST_MUL1,
    ST_MUL2,
    ST_ACC,
    ST_ADV,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_OUT_MUL,
    ST_OUT_SUM
  } state_t;

  typedef struct packed {
    logic [LEN_W-1:0]  attack_len;
    logic [LEN_W-1:0]  decay_len;
    logic [LEN_W-1:0]  sustain_len;
    logic [LEN_W-1:0]  release_len;
    logic [SL_W-1:0]   sustain_level;
    logic [FREQ_W-1:0] note_freq;
    logic [LVL_W-1:0]  note_volume;
    logic [LVL_W-1:0]  pan_right;
    wave_t             wave_kind;
    logic [OFF_W-1:0]  offset;
    logic [PH_W-1:0]   phase;
  } voice_t;

  // Quarter-wave odd polynomial, evaluated at elaboration for the sine table.
  function automatic logic signed [15:0] sine_poly(input logic [63:0] p);
    logic [63:0] quad;
    logic [63:0] f;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] acc;
    quad = (p >> 16) & 64'd3;
    f    = p & 64'hFFFF;
    y    = quad[0] ? (64'd65536 - f) : f;
    y2   = (y * y) >> 16;
    acc  = 64'd5223 - ((64'd307 * y2) >> 16);
    acc  = 64'd42334 - ((acc * y2) >> 16);
    acc  = 64'd102944 - ((acc * y2) >> 16);
    acc  = ((acc * y) >> 16) >> 1;
    if (acc > 64'd32767) acc = 64'd32767;
    return quad[1] ? -$signed(acc[15:0]) : $signed(acc[15:0]);
  endfunction

endpackage

// File: design/polyphonic_adsr_voice_mixer.sv
// Polyphonic voice mixer: voice store in a synchronous memory, serial divider for the envelope.
// A note_on transaction is written to the voice store from the idle state. A tick walks the active
// voices one at a time: load, wave (a reciprocal multiply for a sine or saw voice), envelope (a
// serial divide, skipped at sustain level or past release), two multiplies, accumulate, advance.
// A freed voice is refilled from the last voice, which is walked next; the sum is then scaled.
// Reset clears the voice count, drop flag and output valid, seeds the LFSR.
module polyphonic_adsr_voice_mixer #(
  parameter int VOICES       = 16,
  parameter int SAMPLE_RATE  = 44100,
  parameter int SINE_ENTRIES = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // note_freq, note_volume, attack_len, decay_len, sustain_len, release_len,
  // sustain_level, pan_right, wave_kind
  input  logic [pvm_pkg::IN_W-1:0]  in_tdata,
  input  logic                      in_tuser,   // op
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // right_sample, left_sample, voices_active, notes_dropped, zero fill
  output logic [pvm_pkg::OUT_W-1:0] out_tdata
);

  localparam int CNT_W  = $clog2(VOICES + 1);
  localparam int IDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SIDX_W = $clog2(SINE_ENTRIES);
  localparam int ACC_W  = 50 + $clog2(VOICES + 1);
  localparam int RCP_SH = 34;
  localparam int RCP_W  = 38;
  localparam int RCP_H  = 19;
  localparam int PRD_W  = pvm_pkg::PH_W + RCP_H;
  localparam int SUM_W  = pvm_pkg::PH_W + RCP_W;
  localparam logic [CNT_W-1:0] VOICES_C = CNT_W'(VOICES);
  localparam logic [pvm_pkg::PH_W:0] RATE_C = (pvm_pkg::PH_W + 1)'(SAMPLE_RATE);
  localparam logic [pvm_pkg::QUO_W-1:0] SINE_C = pvm_pkg::QUO_W'(SINE_ENTRIES);
  // Rounded-up reciprocals of the sample rate, exact for any phase below the rate.
  localparam logic [RCP_W-1:0] RCP_SINE =
    RCP_W'(((64'(SINE_ENTRIES) << RCP_SH) + 64'(SAMPLE_RATE) - 64'd1) / 64'(SAMPLE_RATE));
  localparam logic [RCP_W-1:0] RCP_SAW =
    RCP_W'(((64'd1 << (RCP_SH + 16)) + 64'(SAMPLE_RATE) - 64'd1) / 64'(SAMPLE_RATE));
  localparam logic signed [ACC_W-1:0] CLAMP_HI = ACC_W'(64'd3 << 47);
  localparam logic signed [ACC_W-1:0] CLAMP_LO = -CLAMP_HI;

  // Sine table, a constant ROM.
  logic signed [15:0] sine_tab [SINE_ENTRIES];
  for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_sine
    localparam logic [63:0] POS = (64'(g) << 18) / SINE_ENTRIES;
    assign sine_tab[g] = pvm_pkg::sine_poly(POS);
  end

  // Input fields.
  logic [pvm_pkg::FREQ_W-1:0] in_freq;
  logic [pvm_pkg::LVL_W-1:0]  in_vol;
  logic [pvm_pkg::LEN_W-1:0]  in_a, in_d, in_s, in_r;
  logic [pvm_pkg::SL_W-1:0]   in_sl;
  logic [pvm_pkg::LVL_W-1:0]  in_pan;
  logic [1:0]                 in_kind;
  pvm_pkg::voice_t            new_voice;

  assign in_freq = in_tdata[11:0];
  assign in_vol  = in_tdata[20:12];
  assign in_a    = in_tdata[40:21];
  assign in_d    = in_tdata[60:41];
  assign in_s    = in_tdata[80:61];
  assign in_r    = in_tdata[100:81];
  assign in_sl   = in_tdata[116:101];
  assign in_pan  = in_tdata[125:117];
  assign in_kind = in_tdata[127:126];

  always_comb begin
    new_voice.attack_len    = in_a;
    new_voice.decay_len     = in_d;
    new_voice.sustain_len   = in_s;
    new_voice.release_len   = in_r;
    new_voice.sustain_level = in_sl;
    new_voice.note_freq     = in_freq;
    new_voice.note_volume   = (in_vol > pvm_pkg::LVL_FULL) ? pvm_pkg::LVL_FULL : in_vol;
    new_voice.pan_right     = (in_pan > pvm_pkg::LVL_FULL) ? pvm_pkg::LVL_FULL : in_pan;
    new_voice.wave_kind     = pvm_pkg::wave_t'(in_kind);
    new_voice.offset        = '0;
    new_voice.phase         = '0;
  end

  // Control and datapath registers.
  pvm_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] idx_r;
  logic [15:0]      lfsr_r;
  logic             drop_r;
  pvm_pkg::voice_t  v_r;
  logic [pvm_pkg::OFF_W-1:0] len_r, ad_r, ads_r, adsr_r;
  logic signed [15:0] w_r;
  logic [pvm_pkg::QUO_W-1:0] env_r;
  pvm_pkg::env_mode_t env_mode_r;
  logic signed [31:0] m1_r;
  logic signed [39:0] m2_r;
  logic signed [ACC_W-1:0] racc_r, lacc_r;
  logic [38:0] rhi_r, lhi_r;
  logic [37:0] rlo_r, llo_r;
  logic        rneg_r, lneg_r;
  logic        out_valid_r;
  logic [15:0] out_right_r, out_left_r;
  logic [4:0]  out_voices_r;
  logic        out_drop_r;

  // Voice memory.
  pvm_pkg::voice_t vmem [VOICES];
  logic            vmem_we;
  logic [IDX_W-1:0] vmem_waddr, vmem_raddr;
  pvm_pkg::voice_t vmem_wdata, vmem_rdata_r;

  always_ff @(posedge clk) begin
    if (vmem_we) vmem[vmem_waddr] <= vmem_wdata;
    vmem_rdata_r <= vmem[vmem_raddr];
  end

  // Serial restoring divider, one quotient bit per cycle.
  logic                        div_load;
  logic [pvm_pkg::NUM_W-1:0]   div_num;
  logic [pvm_pkg::DEN_W-1:0]   div_den;
  logic [pvm_pkg::REM_W-1:0]   div_rem_r;
  logic [pvm_pkg::QUO_W-1:0]   div_low_r;
  logic [pvm_pkg::DEN_W-1:0]   div_den_r;
  logic [pvm_pkg::QUO_W-1:0]   div_q_r;
  logic [pvm_pkg::DCNT_W-1:0]  div_cnt_r;
  logic [pvm_pkg::REM_W:0]     div_trial;
  logic                        div_ge;
  logic                        div_done;

  assign div_trial = {div_rem_r, div_low_r[pvm_pkg::QUO_W-1]};
  assign div_ge    = div_trial >= (pvm_pkg::REM_W + 1)'(div_den_r);
  assign div_done  = div_cnt_r == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (div_load) begin
      div_rem_r <= div_num[pvm_pkg::NUM_W-1:pvm_pkg::QUO_W];
      div_low_r <= div_num[pvm_pkg::QUO_W-1:0];
      div_den_r <= div_den;
      div_q_r   <= '0;
      div_cnt_r <= pvm_pkg::DCNT_W'(pvm_pkg::QUO_W);
    end else if (!div_done) begin
      div_rem_r <= div_ge ? pvm_pkg::REM_W'(div_trial - (pvm_pkg::REM_W + 1)'(div_den_r))
                          : div_trial[pvm_pkg::REM_W-1:0];
      div_low_r <= {div_low_r[pvm_pkg::QUO_W-2:0], 1'b0};
      div_q_r   <= {div_q_r[pvm_pkg::QUO_W-2:0], div_ge};
      div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  // Per-voice derived values.
  logic [pvm_pkg::LEN_W-1:0] a1, d1, s1, r1;
  logic [pvm_pkg::OFF_W-1:0] t_off;
  logic [pvm_pkg::OFF_W:0]   off_inc;
  logic [pvm_pkg::PH_W:0]    ph_sum;
  logic [pvm_pkg::PH_W-1:0]  ph_next;
  logic [15:0]               lfsr_next;
  logic [SIDX_W-1:0]         sidx;
  logic [CNT_W-1:0]          last_idx;
  logic [RCP_W-1:0]          rcp;
  logic [PRD_W-1:0]          rp_hi_r, rp_lo_r;
  logic [SUM_W-1:0]          rp_sum;
  logic [pvm_pkg::QUO_W-1:0] wq;

  assign a1 = (v_r.attack_len  == '0) ? pvm_pkg::LEN_W'(1) : v_r.attack_len;
  assign d1 = (v_r.decay_len   == '0) ? pvm_pkg::LEN_W'(1) : v_r.decay_len;
  assign s1 = (v_r.sustain_len == '0) ? pvm_pkg::LEN_W'(1) : v_r.sustain_len;
  assign r1 = (v_r.release_len == '0) ? pvm_pkg::LEN_W'(1) : v_r.release_len;
  assign t_off   = v_r.offset;
  assign off_inc = (pvm_pkg::OFF_W + 1)'(v_r.offset) + 1'b1;
  assign ph_sum  = (pvm_pkg::PH_W + 1)'(v_r.phase) + (pvm_pkg::PH_W + 1)'(v_r.note_freq);
  assign ph_next = (ph_sum >= RATE_C) ? pvm_pkg::PH_W'(ph_sum - RATE_C)
                                      : ph_sum[pvm_pkg::PH_W-1:0];
  assign lfsr_next = {1'b0, lfsr_r[15:1]} ^ (lfsr_r[0] ? pvm_pkg::LFSR_TAPS : 16'h0000);
  // phase over sample rate by reciprocal multiply, split in two partial products
  assign rcp    = (v_r.wave_kind == pvm_pkg::WAVE_SINE) ? RCP_SINE : RCP_SAW;
  assign rp_sum = {rp_hi_r, {RCP_H{1'b0}}} + SUM_W'(rp_lo_r);
  assign wq     = rp_sum[RCP_SH+pvm_pkg::QUO_W-1:RCP_SH];
  assign sidx = (wq >= SINE_C) ? SIDX_W'(SINE_ENTRIES - 1) : wq[SIDX_W-1:0];
  assign last_idx = cnt_r - 1'b1;

  // Envelope region select.
  pvm_pkg::env_mode_t        env_mode;
  logic [pvm_pkg::QUO_W-1:0] env_direct;
  logic [pvm_pkg::NUM_W-1:0] env_num;
  logic [pvm_pkg::DEN_W-1:0] env_den;

  always_comb begin
    env_mode   = pvm_pkg::ENV_DIRECT;
    env_direct = '0;
    env_num    = '0;
    env_den    = a1;
    if (t_off <= pvm_pkg::OFF_W'(a1)) begin
      env_mode = pvm_pkg::ENV_RISE;
      env_num  = {t_off, 16'h0000};
    end else if (t_off <= ad_r) begin
      env_mode = pvm_pkg::ENV_FALL;
      env_num  = pvm_pkg::NUM_W'((pvm_pkg::ENV_FULL - pvm_pkg::QUO_W'(v_r.sustain_level)) *
                                 (t_off - pvm_pkg::OFF_W'(a1)));
      env_den  = d1;
    end else if (t_off <= ads_r) begin
      env_direct = pvm_pkg::QUO_W'(v_r.sustain_level);
    end else if (t_off <= adsr_r) begin
      env_mode = pvm_pkg::ENV_RELEASE;
      env_num  = pvm_pkg::NUM_W'(v_r.sustain_level * (t_off - ads_r));
      env_den  = r1;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pvm_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state, memory port and divider control.
  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    vmem_we    = 1'b0;
    vmem_waddr = idx_r[IDX_W-1:0];
    vmem_wdata = v_r;
    vmem_raddr = idx_r[IDX_W-1:0];
    div_load   = 1'b0;
    div_num    = '0;
    div_den    = env_den;
    case (state_r)
      pvm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == pvm_pkg::OP_TICK) begin
            state_nxt = pvm_pkg::ST_CHECK;
          end else if (in_tuser == pvm_pkg::OP_NOTE_ON && cnt_r < VOICES_C) begin
            vmem_we    = 1'b1;
            vmem_waddr = cnt_r[IDX_W-1:0];
            vmem_wdata = new_voice;
          end
        end
      end
      pvm_pkg::ST_CHECK: begin
        state_nxt = (idx_r < cnt_r) ? pvm_pkg::ST_LOAD : pvm_pkg::ST_OUT_MUL;
      end
      pvm_pkg::ST_LOAD: state_nxt = pvm_pkg::ST_WAVE;
      pvm_pkg::ST_WAVE: begin
        case (v_r.wave_kind)
          pvm_pkg::WAVE_SINE, pvm_pkg::WAVE_SAW: state_nxt = pvm_pkg::ST_WDIV;
          default: state_nxt = pvm_pkg::ST_ENV;
        endcase
      end
      pvm_pkg::ST_WDIV: state_nxt = pvm_pkg::ST_ENV;
      pvm_pkg::ST_ENV: begin
        if (env_mode == pvm_pkg::ENV_DIRECT) begin
          state_nxt = pvm_pkg::ST_MUL1;
        end else begin
          div_load  = 1'b1;
          div_num   = env_num;
          state_nxt = pvm_pkg::ST_EDIV;
        end
      end
      pvm_pkg::ST_EDIV: begin
        if (div_done) state_nxt = pvm_pkg::ST_MUL1;
      end
      pvm_pkg::ST_MUL1: state_nxt = pvm_pkg::ST_MUL2;
      pvm_pkg::ST_MUL2: state_nxt = pvm_pkg::ST_ACC;
      pvm_pkg::ST_ACC:  state_nxt = pvm_pkg::ST_ADV;
      pvm_pkg::ST_ADV: begin
        if (off_inc >= (pvm_pkg::OFF_W + 1)'(len_r)) begin
          state_nxt = pvm_pkg::ST_MOVE_RD;
        end else begin
          vmem_we           = 1'b1;
          vmem_wdata.offset = off_inc[pvm_pkg::OFF_W-1:0];
          vmem_wdata.phase  = ph_next;
          state_nxt         = pvm_pkg::ST_CHECK;
        end
      end
      pvm_pkg::ST_MOVE_RD: begin
        // fetch the last voice to fill the freed slot
        vmem_raddr = last_idx[IDX_W-1:0];
        state_nxt  = pvm_pkg::ST_MOVE_WR;
      end
      pvm_pkg::ST_MOVE_WR: begin
        vmem_we    = 1'b1;
        vmem_wdata = vmem_rdata_r;
        state_nxt  = pvm_pkg::ST_CHECK;
      end
      pvm_pkg::ST_OUT_MUL: state_nxt = pvm_pkg::ST_OUT_SUM;
      pvm_pkg::ST_OUT_SUM: begin
        if (!out_valid_r || out_tready) state_nxt = pvm_pkg::ST_IDLE;
      end
      default: state_nxt = pvm_pkg::ST_IDLE;
    endcase
  end

  // Output scaling.
  logic signed [ACC_W-1:0] rcl, lcl;
  logic [ACC_W-1:0]        rmag, lmag;
  logic [62:0]             rtot, ltot;

  assign rcl  = (racc_r > CLAMP_HI) ? CLAMP_HI : ((racc_r < CLAMP_LO) ? CLAMP_LO : racc_r);
  assign lcl  = (lacc_r > CLAMP_HI) ? CLAMP_HI : ((lacc_r < CLAMP_LO) ? CLAMP_LO : lacc_r);
  assign rmag = rcl[ACC_W-1] ? -rcl : rcl;
  assign lmag = lcl[ACC_W-1] ? -lcl : lcl;
  assign rtot = {rhi_r, 24'h000000} + 63'(rlo_r);
  assign ltot = {lhi_r, 24'h000000} + 63'(llo_r);

  // Datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      lfsr_r      <= pvm_pkg::LFSR_SEED;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (out_valid_r && out_tready && state_r != pvm_pkg::ST_OUT_SUM) out_valid_r <= 1'b0;
      case (state_r)
        pvm_pkg::ST_IDLE: begin
          if (in_tvalid) begin
            if (in_tuser == pvm_pkg::OP_TICK) begin
              idx_r  <= '0;
              racc_r <= '0;
              lacc_r <= '0;
            end else if (cnt_r < VOICES_C) begin
              cnt_r <= cnt_r + 1'b1;
            end else begin
              drop_r <= 1'b1;
            end
          end
        end
        pvm_pkg::ST_LOAD: v_r <= vmem_rdata_r;
        pvm_pkg::ST_WAVE: begin
          len_r  <= pvm_pkg::OFF_W'(v_r.attack_len) + pvm_pkg::OFF_W'(v_r.decay_len) +
                    pvm_pkg::OFF_W'(v_r.sustain_len) + pvm_pkg::OFF_W'(v_r.release_len);
          ad_r   <= pvm_pkg::OFF_W'(a1) + pvm_pkg::OFF_W'(d1);
          ads_r  <= pvm_pkg::OFF_W'(a1) + pvm_pkg::OFF_W'(d1) + pvm_pkg::OFF_W'(s1);
          adsr_r <= pvm_pkg::OFF_W'(a1) + pvm_pkg::OFF_W'(d1) + pvm_pkg::OFF_W'(s1) +
                    pvm_pkg::OFF_W'(r1);
          rp_hi_r <= v_r.phase * rcp[RCP_W-1:RCP_H];
          rp_lo_r <= v_r.phase * rcp[RCP_H-1:0];
          if (v_r.wave_kind == pvm_pkg::WAVE_SQUARE) begin
            w_r <= ({v_r.phase, 1'b0} > RATE_C) ? 16'sh7FFF : 16'sh8000;
          end else if (v_r.wave_kind == pvm_pkg::WAVE_NOISE) begin
            lfsr_r <= lfsr_next;
            w_r    <= $signed({~lfsr_next[15], lfsr_next[14:0]});
          end
        end
        pvm_pkg::ST_WDIV: begin
          w_r <= (v_r.wave_kind == pvm_pkg::WAVE_SINE) ? sine_tab[sidx]
                                                       : $signed({~wq[15], wq[14:0]});
        end
        pvm_pkg::ST_ENV: begin
          env_mode_r <= env_mode;
          env_r      <= env_direct;
        end
        pvm_pkg::ST_EDIV: begin
          if (div_done) begin
            case (env_mode_r)
              pvm_pkg::ENV_FALL:    env_r <= pvm_pkg::ENV_FULL - div_q_r;
              pvm_pkg::ENV_RELEASE: env_r <= pvm_pkg::QUO_W'(v_r.sustain_level) - div_q_r;
              default:              env_r <= div_q_r;
            endcase
          end
        end
        pvm_pkg::ST_MUL1: m1_r <= w_r * $signed({1'b0, env_r});
        pvm_pkg::ST_MUL2: m2_r <= m1_r * $signed({1'b0, v_r.note_volume});
        pvm_pkg::ST_ACC: begin
          racc_r <= racc_r + ((m2_r * $signed({1'b0, v_r.pan_right})) <<< 1);
          lacc_r <= lacc_r +
                    ((m2_r * $signed({1'b0, pvm_pkg::LVL_FULL - v_r.pan_right})) <<< 1);
        end
        pvm_pkg::ST_ADV: begin
          if (off_inc < (pvm_pkg::OFF_W + 1)'(len_r)) idx_r <= idx_r + 1'b1;
        end
        pvm_pkg::ST_MOVE_WR: cnt_r <= cnt_r - 1'b1;
        pvm_pkg::ST_OUT_MUL: begin
          rneg_r <= rcl[ACC_W-1];
          lneg_r <= lcl[ACC_W-1];
          rhi_r  <= rmag[pvm_pkg::MAG_W-1:pvm_pkg::SPLIT] * pvm_pkg::OUT_SCALE;
          rlo_r  <= rmag[pvm_pkg::SPLIT-1:0] * pvm_pkg::OUT_SCALE;
          lhi_r  <= lmag[pvm_pkg::MAG_W-1:pvm_pkg::SPLIT] * pvm_pkg::OUT_SCALE;
          llo_r  <= lmag[pvm_pkg::SPLIT-1:0] * pvm_pkg::OUT_SCALE;
        end
        pvm_pkg::ST_OUT_SUM: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_right_r  <= rneg_r ? -rtot[62:47] : rtot[62:47];
            out_left_r   <= lneg_r ? -ltot[62:47] : ltot[62:47];
            out_voices_r <= 5'(cnt_r);
            out_drop_r   <= drop_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_drop_r, out_voices_r, out_left_r, out_right_r};

endmodule

// File: tb/sv/testbench.sv
// Self-checking bench for the polyphonic ADSR voice mixer: directed table, then random notes and ticks.
module testbench;

  localparam int NVOICE     = 16;
  localparam int RATE       = 44100;
  localparam int SINE_N     = 256;
  localparam int RAND_ITEMS = 725;
  localparam int STALL_LIM  = 20000;
  localparam int HOLD_CYC   = 3000;

  typedef struct {
    logic [19:0] att, dec, sus, rel;
    logic [15:0] lvl;
    logic [11:0] freq;
    logic [8:0]  vol, pan;
    pvm_pkg::wave_t kind;
    longint unsigned off, ph;
  } note_rec_t;

  typedef struct {
    logic         op;
    logic [127:0] data;
    bit           typed;
    logic [39:0]  res;
  } row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [39:0]  out_tdata;

  logic signed [15:0] sine_tab [SINE_N];
  note_rec_t   notes [NVOICE];
  int unsigned note_cnt;
  logic [15:0] noise_reg;
  bit          drop_seen;

  logic [39:0] pending_samples [$];
  int  mismatches = 0;
  int  items_sent = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;
  row_t rows [$];

  polyphonic_adsr_voice_mixer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [15:0] sine_entry(int idx);
    longint unsigned p, quad, f, y, y2, acc;
    p    = (longint'(idx) << 18) / SINE_N;
    quad = (p >> 16) & 3;
    f    = p & 16'hFFFF;
    y    = quad[0] ? (65536 - f) : f;
    y2   = (y * y) >> 16;
    acc  = 5223 - ((307 * y2) >> 16);
    acc  = 42334 - ((acc * y2) >> 16);
    acc  = 102944 - ((acc * y2) >> 16);
    acc  = ((acc * y) >> 16) >> 1;
    if (acc > 32767) acc = 32767;
    return quad[1] ? -$signed(acc[15:0]) : $signed(acc[15:0]);
  endfunction

  function automatic logic [127:0] note_word(logic [11:0] freq, logic [8:0] vol,
      logic [19:0] att, logic [19:0] dec, logic [19:0] sus, logic [19:0] rel,
      logic [15:0] lvl, logic [8:0] pan, pvm_pkg::wave_t kind);
    return {kind, pan, lvl, rel, sus, dec, att, vol, freq};
  endfunction

  function automatic longint unsigned env_at(note_rec_t n);
    longint unsigned t, a, d, s, r, sl;
    t  = n.off;
    a  = (n.att == 0) ? 1 : n.att;
    d  = (n.dec == 0) ? 1 : n.dec;
    s  = (n.sus == 0) ? 1 : n.sus;
    r  = (n.rel == 0) ? 1 : n.rel;
    sl = n.lvl;
    if (t <= a) return (t << 16) / a;
    if (t <= a + d) return 65536 - ((65536 - sl) * (t - a)) / d;
    if (t <= a + d + s) return sl;
    if (t <= a + d + s + r) return sl - (sl * (t - a - d - s)) / r;
    return 0;
  endfunction

  function automatic logic [15:0] scale_sum(longint acc);
    longint lim;
    longint unsigned mag;
    bit neg;
    lim = longint'(3) << 47;
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    neg = acc < 0;
    mag = neg ? -acc : acc;
    mag = (mag * 10922) >> 47;
    return neg ? 16'(-mag) : 16'(mag);
  endfunction

  function automatic void store_note(logic [127:0] d);
    note_rec_t n;
    if (note_cnt >= NVOICE) begin
      drop_seen = 1'b1;
      return;
    end
    n.freq = d[11:0];
    n.vol  = (d[20:12] > 256) ? 9'd256 : d[20:12];
    n.att  = d[40:21];
    n.dec  = d[60:41];
    n.sus  = d[80:61];
    n.rel  = d[100:81];
    n.lvl  = d[116:101];
    n.pan  = (d[125:117] > 256) ? 9'd256 : d[125:117];
    n.kind = pvm_pkg::wave_t'(d[127:126]);
    n.off  = 0;
    n.ph   = 0;
    notes[note_cnt] = n;
    note_cnt++;
  endfunction

  function automatic logic [39:0] mix_tick();
    longint racc, lacc, w, smp;
    longint unsigned idx, len, off;
    int unsigned i;
    logic lsb;
    racc = 0;
    lacc = 0;
    i = 0;
    while (i < note_cnt) begin
      case (notes[i].kind)
        pvm_pkg::WAVE_SINE: begin
          idx = (notes[i].ph * SINE_N) / RATE;
          if (idx >= SINE_N) idx = SINE_N - 1;
          w = sine_tab[idx];
        end
        pvm_pkg::WAVE_SQUARE: w = (2 * notes[i].ph > RATE) ? 32767 : -32768;
        pvm_pkg::WAVE_SAW:    w = longint'((notes[i].ph << 16) / RATE) - 32768;
        default: begin
          lsb = noise_reg[0];
          noise_reg = noise_reg >> 1;
          if (lsb) noise_reg = noise_reg ^ 16'hB400;
          w = longint'(noise_reg) - 32768;
        end
      endcase
      smp = w * longint'(env_at(notes[i])) * longint'(notes[i].vol) * 2;
      racc += smp * longint'(notes[i].pan);
      lacc += smp * (256 - longint'(notes[i].pan));
      len = longint'(notes[i].att) + notes[i].dec + notes[i].sus + notes[i].rel;
      off = notes[i].off + 1;
      if (off >= len) begin
        // last voice fills the hole and is walked in this same tick
        notes[i] = notes[note_cnt - 1];
        note_cnt--;
      end else begin
        notes[i].off = off;
        notes[i].ph  = (notes[i].ph + notes[i].freq) % RATE;
        i++;
      end
    end
    return {2'b00, drop_seen, 5'(note_cnt), scale_sum(lacc), scale_sum(racc)};
  endfunction

  task automatic send_item(logic op, logic [127:0] d, bit typed, logic [39:0] res);
    logic [39:0] pred;
    if (!quiet && $urandom_range(0, 99) < 10) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (op == pvm_pkg::OP_NOTE_ON) begin
      store_note(d);
    end else begin
      pred = mix_tick();
      pending_samples.push_back(typed ? res : pred);
    end
  endtask

  function automatic logic [19:0] rand_len();
    // rare full-range lengths keep a voice alive for the whole run
    if ($urandom_range(0, 99) == 0) return 20'($urandom);
    return 20'($urandom_range(0, 12));
  endfunction

  // receiver: random stalls plus one long hold-off so the input backs up
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (!hold_done && items_sent >= 400) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYC;
        out_tready <= 1'b0;
      end else begin
        out_tready <= quiet || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  always @(posedge clk) begin
    logic [39:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample %h", out_tdata);
      end else begin
        want = pending_samples.pop_front();
        if (out_tdata[15:0] !== want[15:0] || out_tdata[31:16] !== want[31:16] ||
            out_tdata[36:32] !== want[36:32] || out_tdata[37] !== want[37]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample mismatch: right %0d/%0d left %0d/%0d voices %0d/%0d drop %0b/%0b",
                     $signed(want[15:0]), $signed(out_tdata[15:0]),
                     $signed(want[31:16]), $signed(out_tdata[31:16]),
                     want[36:32], out_tdata[36:32], want[37], out_tdata[37]);
        end
      end
    end
  end

  // watchdog: count cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIM) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    row_t rw;
    int k;
    logic op;
    for (k = 0; k < SINE_N; k++) sine_tab[k] = sine_entry(k);
    note_cnt  = 0;
    noise_reg = 16'hACE1;
    drop_seen = 1'b0;

    // directed table
    rw = '{pvm_pkg::OP_TICK, '0, 1'b1, 40'h0};
    rows.push_back(rw);
    rw = '{pvm_pkg::OP_NOTE_ON, note_word(12'hFFF, 9'h1FF, 0, 0, 0, 0, 16'hFFFF, 9'h1FF,
           pvm_pkg::WAVE_SINE), 1'b0, '0};
    rows.push_back(rw);
    rw = '{pvm_pkg::OP_TICK, '0, 1'b0, '0};
    rows.push_back(rw);
    rw = '{pvm_pkg::OP_NOTE_ON, note_word(12'd0, 9'd256, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
           20'hFFFFF, 16'h0, 9'd0, pvm_pkg::WAVE_SQUARE), 1'b0, '0};
    rows.push_back(rw);
    rw = '{pvm_pkg::OP_NOTE_ON, note_word(12'd1000, 9'd0, 3, 2, 4, 5, 16'h8000, 9'd128,
           pvm_pkg::WAVE_SAW), 1'b0, '0};
    rows.push_back(rw);
    rw = '{pvm_pkg::OP_NOTE_ON, note_word(12'd440, 9'd200, 1, 1, 1, 1, 16'h4000, 9'd256,
           pvm_pkg::WAVE_NOISE), 1'b0, '0};
    rows.push_back(rw);
    rw = '{pvm_pkg::OP_TICK, '0, 1'b0, '0};
    rows.push_back(rw);
    rw = '{pvm_pkg::OP_TICK, '0, 1'b0, '0};
    rows.push_back(rw);
    // overfill the store so the last notes are dropped
    for (k = 0; k < 16; k++) begin
      rw = '{pvm_pkg::OP_NOTE_ON, note_word(12'(100 * k + 7), 9'(16 * k + 16), 20'(k % 3), 1,
             2, 20'(k % 2), 16'(4000 * k), 9'(k * 17), pvm_pkg::wave_t'(2'(k % 4))),
             1'b0, '0};
      rows.push_back(rw);
    end
    rw = '{pvm_pkg::OP_TICK, '0, 1'b0, '0};
    rows.push_back(rw);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_item(rows[i].op, rows[i].data, rows[i].typed, rows[i].res);

    for (k = 0; k < RAND_ITEMS; k++) begin
      quiet = (k >= 200 && k < 330);
      op = ($urandom_range(0, 99) < 55) ? pvm_pkg::OP_TICK : pvm_pkg::OP_NOTE_ON;
      if (op == pvm_pkg::OP_TICK)
        send_item(op, {$urandom, $urandom, $urandom, $urandom}, 1'b0, '0);
      else
        send_item(op, note_word(12'($urandom), 9'($urandom), rand_len(), rand_len(),
                  rand_len(), rand_len(), 16'($urandom), 9'($urandom),
                  pvm_pkg::wave_t'(2'($urandom))), 1'b0, '0);
    end
    in_tvalid <= 1'b0;
    quiet = 1'b0;

    while (pending_samples.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
design/pvm_pkg.sv
design/polyphonic_adsr_voice_mixer.sv
tb/sv/testbench.sv
